// ----- design/kvt_pkg.sv -----
// ----------------------------------------------------------------------------
// kvt_pkg
// Shared types, codes and defaults for the key/value table.
// ----------------------------------------------------------------------------
package kvt_pkg;

	localparam int CAPACITY_DEF = 16;

	localparam logic [1:0] OP_PUT    = 2'd0;
	localparam logic [1:0] OP_FIND   = 2'd1;
	localparam logic [1:0] OP_REMOVE = 2'd2;

	localparam logic [2:0] ST_INSERTED  = 3'd0;
	localparam logic [2:0] ST_UPDATED   = 3'd1;
	localparam logic [2:0] ST_FOUND     = 3'd2;
	localparam logic [2:0] ST_NOT_FOUND = 3'd3;
	localparam logic [2:0] ST_REMOVED   = 3'd4;
	localparam logic [2:0] ST_FULL      = 3'd5;

	typedef struct packed {
		logic [1:0]          operation;
		logic signed [31:0]  lookup_key;
		logic signed [31:0]  new_value;
	} req_t;

	typedef struct packed {
		logic [2:0]          status;
		logic signed [31:0]  found_value;
		logic [4:0]          entry_total;
	} rsp_t;

	typedef struct packed {
		logic                valid;
		logic signed [31:0]  key;
		logic signed [31:0]  value;
	} entry_t;

	typedef struct packed {
		logic clear;
		logic start;
		logic scan;
		logic commit;
	} cmd_t;

	typedef struct packed {
		logic last;
		logic out_free;
	} sts_t;

endpackage

// ----- design/kvt_ctrl.sv -----
// ----------------------------------------------------------------------------
// kvt_ctrl
// Sequencer: clearing pass, scan of all entries, wait for last read, commit.
// ----------------------------------------------------------------------------
module kvt_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  kvt_pkg::sts_t sts,
	output kvt_pkg::cmd_t cmd
);

	typedef enum logic [4:0] {
		S_CLEAR  = 5'b00001,
		S_IDLE   = 5'b00010,
		S_SCAN   = 5'b00100,
		S_WAIT   = 5'b01000,
		S_FINISH = 5'b10000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLEAR:  if (sts.last) state_d = S_IDLE;
			S_IDLE:   if (req_valid) state_d = S_SCAN;
			S_SCAN:   if (sts.last) state_d = S_WAIT;
			S_WAIT:   state_d = S_FINISH;
			S_FINISH: if (sts.out_free) state_d = S_IDLE;
			default:  state_d = S_CLEAR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	assign req_ready  = (state_q == S_IDLE);
	assign cmd.clear  = (state_q == S_CLEAR);
	assign cmd.start  = (state_q == S_IDLE) && req_valid;
	assign cmd.scan   = (state_q == S_SCAN);
	assign cmd.commit = (state_q == S_FINISH) && sts.out_free;

endmodule

// ----- design/kvt_datapath.sv -----
// ----------------------------------------------------------------------------
// kvt_datapath
// Entry memory, scan counter, match and free trackers, result register.
// ----------------------------------------------------------------------------
module kvt_datapath #(
	parameter int CAPACITY = kvt_pkg::CAPACITY_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  kvt_pkg::cmd_t cmd,
	output kvt_pkg::sts_t sts,
	input  kvt_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output kvt_pkg::rsp_t rsp
);

	localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int TOT_W = $clog2(CAPACITY + 1);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);

	kvt_pkg::entry_t mem_q [CAPACITY];
	kvt_pkg::entry_t rd_s1;
	logic [IDX_W-1:0] idx_s1;
	logic             chk_s1;

	logic [IDX_W-1:0] cnt_q;
	kvt_pkg::req_t    req_q;
	logic             hit_q, free_q;
	logic [IDX_W-1:0] hit_idx_q, free_idx_q;
	logic signed [31:0] hit_val_q;
	logic [TOT_W-1:0] total_q, total_d;
	logic [TOT_W+4:0] total_ext;

	logic             wr_en;
	logic [IDX_W-1:0] wr_addr;
	kvt_pkg::entry_t  wr_data;
	kvt_pkg::rsp_t    res_d;
	kvt_pkg::rsp_t    rsp_q;
	logic             rsp_valid_q;

	assign sts.last     = (cnt_q == LAST_IDX);
	assign sts.out_free = !rsp_valid_q || rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.clear || cmd.scan) begin
			cnt_q <= sts.last ? '0 : cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_s1  <= mem_q[cnt_q];
		idx_s1 <= cnt_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chk_s1 <= 1'b0;
		end else begin
			chk_s1 <= cmd.scan;
		end
	end

	// track lowest matching and lowest free entry
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			req_q  <= req;
			hit_q  <= 1'b0;
			free_q <= 1'b0;
		end else if (chk_s1) begin
			if (rd_s1.valid && (rd_s1.key == req_q.lookup_key) && !hit_q) begin
				hit_q     <= 1'b1;
				hit_idx_q <= idx_s1;
				hit_val_q <= rd_s1.value;
			end
			if (!rd_s1.valid && !free_q) begin
				free_q     <= 1'b1;
				free_idx_q <= idx_s1;
			end
		end
	end

	always_comb begin
		wr_en             = 1'b0;
		wr_addr           = cnt_q;
		wr_data           = '0;
		total_d           = total_q;
		res_d.status      = kvt_pkg::ST_NOT_FOUND;
		res_d.found_value = '0;
		if (cmd.clear) begin
			wr_en = 1'b1;
		end else begin
			unique case (req_q.operation)
				kvt_pkg::OP_PUT: begin
					if (hit_q) begin
						wr_en             = 1'b1;
						wr_addr           = hit_idx_q;
						wr_data           = {1'b1, req_q.lookup_key, req_q.new_value};
						res_d.status      = kvt_pkg::ST_UPDATED;
						res_d.found_value = req_q.new_value;
					end else if (free_q) begin
						wr_en             = 1'b1;
						wr_addr           = free_idx_q;
						wr_data           = {1'b1, req_q.lookup_key, req_q.new_value};
						total_d           = total_q + 1'b1;
						res_d.status      = kvt_pkg::ST_INSERTED;
						res_d.found_value = req_q.new_value;
					end else begin
						res_d.status = kvt_pkg::ST_FULL;
					end
				end
				kvt_pkg::OP_FIND: begin
					if (hit_q) begin
						res_d.status      = kvt_pkg::ST_FOUND;
						res_d.found_value = hit_val_q;
					end
				end
				kvt_pkg::OP_REMOVE: begin
					if (hit_q) begin
						wr_en        = 1'b1;
						wr_addr      = hit_idx_q;
						wr_data      = {1'b0, req_q.lookup_key, hit_val_q};
						res_d.status = kvt_pkg::ST_REMOVED;
						if (total_q != '0) total_d = total_q - 1'b1;
					end
				end
				default: ;
			endcase
			wr_en = wr_en && cmd.commit;
		end
		total_ext         = {5'b0, total_d};
		res_d.entry_total = total_ext[4:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd.commit) begin
				total_q     <= total_d;
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			rsp_q <= res_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// ----- design/key_value_table_top.sv -----
// ----------------------------------------------------------------------------
// key_value_table_top
// Associative key/value table with put, find and remove.
//
//   channel | signals                 | word
//   --------+-------------------------+-------------------------------------
//   request | req_valid, req_ready    | req : operation, lookup_key, new_value
//   result  | rsp_valid, rsp_ready    | rsp : status, found_value, entry_total
//
// Each word is taken, then every entry is read in turn through the single
// read port of the entry memory, the last read completes, and the result
// is committed.
// After reset a clearing pass over all entries runs before the first word.
// A waiting result holds; the next request is taken meanwhile and its
// commit waits until the result register frees.
// ----------------------------------------------------------------------------
module key_value_table_top #(
	parameter int CAPACITY = kvt_pkg::CAPACITY_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  kvt_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output kvt_pkg::rsp_t rsp
);

	kvt_pkg::cmd_t cmd;
	kvt_pkg::sts_t sts;

	kvt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	kvt_datapath #(
		.CAPACITY (CAPACITY)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

endmodule

// ----- design/kvt_checker.sv -----
// ----------------------------------------------------------------------------
// kvt_checker
// Port-level checks for the key/value table.
// ----------------------------------------------------------------------------
module kvt_checker #(
	parameter int CAPACITY = kvt_pkg::CAPACITY_DEF
) (
	input logic          clk,
	input logic          arst_n,
	input logic          req_valid,
	input logic          req_ready,
	input kvt_pkg::req_t req,
	input logic          rsp_valid,
	input logic          rsp_ready,
	input kvt_pkg::rsp_t rsp
);

	localparam logic [4:0] CAP_LO = 5'(CAPACITY);

	a_req_hold: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_ready |=> req_valid && $stable(req))
		else $error("request word dropped or changed while waiting");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("result word dropped or changed while stalled");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while a word is in work");

	a_full_total: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.status == kvt_pkg::ST_FULL) |-> rsp.entry_total == CAP_LO)
		else $error("full status with free entries");

	a_zero_value: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && ((rsp.status == kvt_pkg::ST_NOT_FOUND) ||
		(rsp.status == kvt_pkg::ST_REMOVED) || (rsp.status == kvt_pkg::ST_FULL))
		|-> rsp.found_value == '0)
		else $error("nonzero value for absent key");

endmodule

bind key_value_table_top kvt_checker #(.CAPACITY(CAPACITY)) u_kvt_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_ready (req_ready),
	.req       (req),
	.rsp_valid (rsp_valid),
	.rsp_ready (rsp_ready),
	.rsp       (rsp)
);

// ----- tb/key_value_table_top_tb.sv -----
// ----------------------------------------------------------------------------
// key_value_table_top_tb
// Self-checking bench for the key/value table. A behavioral copy of the table
// predicts the answer to every accepted request word. Answers are compared
// field by field, in order. Directed words cover edge keys, a full table and
// the unused operation code. Random traffic alternates between fill-leaning
// and drain-leaning stretches. Both sides idle at random, and the receiver
// once holds off long enough to stall the request channel.
// ----------------------------------------------------------------------------
module key_value_table_top_tb;

	localparam int                 CAPACITY     = kvt_pkg::CAPACITY_DEF;
	localparam logic [1:0]         OP_UNUSED    = 2'd3;
	localparam logic signed [31:0] KEY_MIN      = 32'sh8000_0000;
	localparam logic signed [31:0] KEY_MAX      = 32'sh7fff_ffff;
	localparam logic signed [31:0] KEY_SPARE    = 32'sh5555_aaaa;
	localparam int                 MAX_GAP      = 13;
	localparam int                 LONG_HOLD    = 300;
	localparam int                 FLOOD_WORDS  = 12;
	localparam int                 RANDOM_ITEMS = 1950;
	localparam int                 SEGMENT      = 75;
	localparam int                 POOL_SIZE    = 20;
	localparam int                 DRAIN_LIMIT  = 4000;
	localparam int                 SETTLE       = 2 * (CAPACITY + 3);
	localparam int                 MAX_PRINTS   = 40;

	logic          clk       = 1'b0;
	logic          arst_n    = 1'b0;
	logic          req_valid = 1'b0;
	logic          req_ready;
	kvt_pkg::req_t req       = '0;
	logic          rsp_valid;
	logic          rsp_ready = 1'b0;
	kvt_pkg::rsp_t rsp;

	logic               model_valid [CAPACITY];
	logic signed [31:0] model_key   [CAPACITY];
	logic signed [31:0] model_value [CAPACITY];
	int                 model_count;
	logic signed [31:0] key_pool    [POOL_SIZE];

	kvt_pkg::rsp_t expected_rsp_q [$];
	int   status_seen [6] = '{default: 0};
	int   mismatch_count  = 0;
	int   words_sent      = 0;
	int   words_checked   = 0;
	bit   no_idle         = 1'b0;
	bit   long_hold_req   = 1'b0;
	int   sink_wait       = 0;
	int   hold_left       = 0;

	key_value_table_top #(
		.CAPACITY(CAPACITY)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	function automatic kvt_pkg::rsp_t table_apply(input kvt_pkg::req_t w);
		kvt_pkg::rsp_t r;
		int   hit;
		int   spare;
		r.status      = kvt_pkg::ST_NOT_FOUND;
		r.found_value = '0;
		hit           = -1;
		spare         = -1;
		for (int i = CAPACITY - 1; i >= 0; i--) begin
			if (model_valid[i] && model_key[i] == w.lookup_key) hit = i;
			if (!model_valid[i]) spare = i;
		end
		case (w.operation)
			kvt_pkg::OP_PUT: begin
				if (hit >= 0) begin
					model_value[hit] = w.new_value;
					r.status         = kvt_pkg::ST_UPDATED;
					r.found_value    = w.new_value;
				end else if (spare >= 0) begin
					model_valid[spare] = 1'b1;
					model_key[spare]   = w.lookup_key;
					model_value[spare] = w.new_value;
					model_count++;
					r.status           = kvt_pkg::ST_INSERTED;
					r.found_value      = w.new_value;
				end else begin
					r.status = kvt_pkg::ST_FULL;
				end
			end
			kvt_pkg::OP_FIND: begin
				if (hit >= 0) begin
					r.status      = kvt_pkg::ST_FOUND;
					r.found_value = model_value[hit];
				end
			end
			kvt_pkg::OP_REMOVE: begin
				if (hit >= 0) begin
					model_valid[hit] = 1'b0;
					if (model_count > 0) model_count--;
					r.status = kvt_pkg::ST_REMOVED;
				end
			end
			default: begin
			end
		endcase
		r.entry_total = model_count[4:0];
		return r;
	endfunction

	function automatic logic signed [31:0] pick_key();
		int live [$];
		int roll;
		for (int i = 0; i < CAPACITY; i++) begin
			if (model_valid[i]) live.push_back(i);
		end
		roll = $urandom_range(99, 0);
		if (roll < 50 && live.size() > 0) return model_key[live[$urandom_range(live.size() - 1, 0)]];
		if (roll < 85) return key_pool[$urandom_range(POOL_SIZE - 1, 0)];
		return $urandom();
	endfunction

	task automatic report_mismatch(input string msg);
		mismatch_count++;
		if (mismatch_count <= MAX_PRINTS) $display("ERROR: result %0d: %s", words_checked, msg);
	endtask

	task automatic send_word(input kvt_pkg::req_t w);
		int gap;
		gap = no_idle ? 0 : $urandom_range(MAX_GAP, 0);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= w;
		do @(posedge clk); while (!req_ready);
		expected_rsp_q.push_back(table_apply(w));
		words_sent++;
	endtask

	task automatic issue(input logic [1:0] op, input logic signed [31:0] key,
			input logic signed [31:0] value);
		kvt_pkg::req_t w;
		w.operation  = op;
		w.lookup_key = key;
		w.new_value  = value;
		send_word(w);
	endtask

	task automatic wait_drained();
		int n;
		n = 0;
		req_valid <= 1'b0;
		do begin
			@(posedge clk);
			n++;
		end while (expected_rsp_q.size() != 0 && n < DRAIN_LIMIT);
		if (expected_rsp_q.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", expected_rsp_q.size()));
	endtask

	always @(posedge clk) begin : result_sink
		kvt_pkg::rsp_t want;
		if (arst_n) begin
			if (rsp_valid && rsp_ready) begin
				if (expected_rsp_q.size() == 0) begin
					report_mismatch("result with nothing expected");
				end else begin
					want = expected_rsp_q.pop_front();
					if (rsp.status !== want.status)
						report_mismatch($sformatf("status %0d, expected %0d",
							rsp.status, want.status));
					if (rsp.found_value !== want.found_value)
						report_mismatch($sformatf("found_value %0d, expected %0d",
							rsp.found_value, want.found_value));
					if (rsp.entry_total !== want.entry_total)
						report_mismatch($sformatf("entry_total %0d, expected %0d",
							rsp.entry_total, want.entry_total));
					if (want.status <= kvt_pkg::ST_FULL) status_seen[want.status]++;
				end
				words_checked++;
				sink_wait = no_idle ? 0 : $urandom_range(MAX_GAP, 0);
			end else if (sink_wait > 0) begin
				sink_wait--;
			end
			if (long_hold_req && hold_left == 0) begin
				hold_left     = LONG_HOLD;
				long_hold_req = 1'b0;
			end else if (hold_left > 0) begin
				hold_left--;
			end
			rsp_ready <= (sink_wait == 0) && (hold_left == 0);
		end
	end

	task automatic test_edge_keys();
		issue(kvt_pkg::OP_FIND, 0, 0);
		issue(kvt_pkg::OP_REMOVE, 0, 0);
		issue(OP_UNUSED, KEY_MIN, KEY_MAX);
		issue(kvt_pkg::OP_PUT, KEY_MIN, KEY_MAX);
		issue(kvt_pkg::OP_PUT, KEY_MIN, KEY_MIN);
		issue(kvt_pkg::OP_FIND, KEY_MIN, 0);
		issue(kvt_pkg::OP_PUT, KEY_MAX, -1);
		issue(kvt_pkg::OP_PUT, 0, 0);
		issue(kvt_pkg::OP_PUT, -1, 1);
		issue(kvt_pkg::OP_REMOVE, KEY_MIN, 0);
		issue(kvt_pkg::OP_FIND, KEY_MIN, 0);
	endtask

	task automatic test_full_table();
		for (int k = 1; k <= CAPACITY - 3; k++)
			issue(kvt_pkg::OP_PUT, k * 32'sh0101_0101, $urandom());
		issue(kvt_pkg::OP_PUT, KEY_SPARE, 7);
		issue(kvt_pkg::OP_PUT, 0, KEY_MIN);
		issue(OP_UNUSED, 0, 0);
		issue(kvt_pkg::OP_REMOVE, KEY_MAX, 0);
		issue(kvt_pkg::OP_PUT, KEY_SPARE, 7);
		issue(kvt_pkg::OP_FIND, KEY_SPARE, 0);
	endtask

	task automatic test_backpressure();
		long_hold_req = 1'b1;
		no_idle       = 1'b1;
		for (int k = 0; k < FLOOD_WORDS; k++)
			issue(k[0] ? kvt_pkg::OP_FIND : kvt_pkg::OP_PUT, pick_key(), $urandom());
		no_idle = 1'b0;
		wait_drained();
	endtask

	task automatic test_random_traffic(input int count);
		kvt_pkg::req_t w;
		int   put_pct;
		int   roll;
		int   done;
		int   seg;
		done = 0;
		seg  = 0;
		while (done < count) begin
			put_pct = seg[0] ? 20 : 60;
			no_idle = ($urandom_range(3, 0) == 0);
			for (int k = 0; k < SEGMENT && done < count; k++) begin
				roll = $urandom_range(99, 0);
				if (roll < 4) w.operation = OP_UNUSED;
				else if (roll < 4 + put_pct) w.operation = kvt_pkg::OP_PUT;
				else if (roll < 24 + put_pct) w.operation = kvt_pkg::OP_FIND;
				else w.operation = kvt_pkg::OP_REMOVE;
				w.lookup_key = pick_key();
				case ($urandom_range(9, 0))
					0: w.new_value = KEY_MIN;
					1: w.new_value = KEY_MAX;
					2: w.new_value = 0;
					default: w.new_value = $urandom();
				endcase
				send_word(w);
				if (w.operation != OP_UNUSED) done++;
			end
			if ($urandom_range(7, 0) == 0) wait_drained();
			seg++;
		end
		no_idle = 1'b0;
	endtask

	initial begin : main
		for (int i = 0; i < CAPACITY; i++) begin
			model_valid[i] = 1'b0;
			model_key[i]   = '0;
			model_value[i] = '0;
		end
		model_count = 0;
		key_pool[0] = KEY_MIN;
		key_pool[1] = KEY_MAX;
		key_pool[2] = 0;
		key_pool[3] = -1;
		key_pool[4] = 1;
		for (int i = 5; i < POOL_SIZE; i++) key_pool[i] = $urandom();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		test_edge_keys();
		test_full_table();
		wait_drained();
		test_backpressure();
		test_random_traffic(RANDOM_ITEMS);
		wait_drained();
		repeat (SETTLE) @(posedge clk);
		$display("Checked %0d of %0d words: %0d inserted, %0d updated, %0d found,",
			words_checked, words_sent, status_seen[kvt_pkg::ST_INSERTED],
			status_seen[kvt_pkg::ST_UPDATED], status_seen[kvt_pkg::ST_FOUND]);
		$display("%0d not found, %0d removed, %0d refused on a full table; %0d mismatches",
			status_seen[kvt_pkg::ST_NOT_FOUND], status_seen[kvt_pkg::ST_REMOVED],
			status_seen[kvt_pkg::ST_FULL], mismatch_count);
		if (mismatch_count == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

	initial begin : watchdog
		#2_000_000;
		$display("Timeout with %0d results outstanding", expected_rsp_q.size());
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
